### sv/caldc_pkg.sv
// ----------------------------------------------------------------------------
// caldc_pkg
// Shared types, constants and calendar functions for the date counter.
// ----------------------------------------------------------------------------
package caldc_pkg;

    // widths of the year register and of the day count
    localparam int YEAR_BITS  = 12;
    localparam int COUNT_BITS = 16;

    // limits applied by a set command
    localparam logic [YEAR_BITS-1:0] YEAR_LOW  = YEAR_BITS'(1900);
    localparam logic [YEAR_BITS-1:0] YEAR_HIGH = YEAR_BITS'(2100);

    // modular inverse of 25 modulo 2^16, truncated to the year width
    localparam logic [15:0]          INV25_FULL = 16'd23593;
    localparam logic [YEAR_BITS-1:0] INV25      = INV25_FULL[YEAR_BITS-1:0];
    // largest product that marks a multiple of 25
    localparam logic [YEAR_BITS-1:0] LIM25      = YEAR_BITS'(((1 << YEAR_BITS) - 1) / 25);

    // month numbers
    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    // command codes
    typedef enum logic [1:0] {
        OP_SET  = 2'd0,
        OP_FWD  = 2'd1,
        OP_BACK = 2'd2
    } t_op;

    // one calendar date
    typedef struct packed {
        logic [YEAR_BITS-1:0] year;
        logic [3:0]           month;
        logic [4:0]           day;
    } t_date;

    // month lengths in a common year
    function automatic logic [4:0] month_len(input logic [3:0] month);
        logic [4:0] len;
        case (month)
            4'd1:    len = 5'd31;
            4'd2:    len = 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // leap year: multiple of 4, and not of 100 unless of 400
    // multiple of 25 found by multiplying with the inverse of 25
    function automatic logic is_leap(input logic [YEAR_BITS-1:0] year);
        logic [2*YEAR_BITS-1:0] prod;
        logic                   div25;
        prod  = {{YEAR_BITS{1'b0}}, year} * {{YEAR_BITS{1'b0}}, INV25};
        div25 = (prod[YEAR_BITS-1:0] <= LIM25);
        return (year[1:0] == 2'd0) && (!div25 || (year[3:0] == 4'd0));
    endfunction

    // days in a month of a given year
    function automatic logic [4:0] days_in(input logic [3:0] month,
                                           input logic [YEAR_BITS-1:0] year);
        logic [4:0] len;
        if ((month == MONTH_FEB) && is_leap(year)) begin
            len = 5'd29;
        end else begin
            len = month_len(month);
        end
        return len;
    endfunction

endpackage

### sv/caldc_step.sv
// ----------------------------------------------------------------------------
// caldc_step
// One-day step unit: moves a date one day forward or one day back.
// ----------------------------------------------------------------------------
module caldc_step (
    input  caldc_pkg::t_date i_date,
    input  logic             i_back,
    output caldc_pkg::t_date o_date
);

    logic [4:0] w_len_cur;
    logic [4:0] w_len_prev;
    logic [3:0] w_prev_month;

    // month lengths needed by either direction
    assign w_prev_month = i_date.month - 4'd1;
    assign w_len_cur    = caldc_pkg::days_in(i_date.month, i_date.year);
    assign w_len_prev   = caldc_pkg::days_in(w_prev_month, i_date.year);

    // next date
    always_comb begin
        o_date = i_date;
        if (!i_back) begin
            if (i_date.day < w_len_cur) begin
                o_date.day = i_date.day + 5'd1;
            end else if (i_date.month < caldc_pkg::MONTH_DEC) begin
                o_date.month = i_date.month + 4'd1;
                o_date.day   = 5'd1;
            end else begin
                o_date.year  = i_date.year + caldc_pkg::YEAR_BITS'(1);
                o_date.month = caldc_pkg::MONTH_JAN;
                o_date.day   = 5'd1;
            end
        end else begin
            if (i_date.day > 5'd1) begin
                o_date.day = i_date.day - 5'd1;
            end else if (i_date.month > caldc_pkg::MONTH_JAN) begin
                o_date.month = w_prev_month;
                o_date.day   = w_len_prev;
            end else begin
                o_date.year  = i_date.year - caldc_pkg::YEAR_BITS'(1);
                o_date.month = caldc_pkg::MONTH_DEC;
                o_date.day   = caldc_pkg::month_len(caldc_pkg::MONTH_DEC);
            end
        end
    end

endmodule

### sv/calendar_date_counter.sv
// ----------------------------------------------------------------------------
// calendar_date_counter
// Gregorian date counter with set, move forward and move back commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. A set command, an
// unused code or a move of zero days passes once through the step state, and
// the result is registered as it leaves; a move of day_count days first takes
// day_count steps, as the single one-day step unit moves one day each cycle.
// busy stays high until the result appears. The result is shown for exactly
// one cycle with o_valid high and cannot be held off, so the receiver must
// take it in that cycle; the next command may be taken in that same cycle.
// Each result gives the date before and the date after the command.
module calendar_date_counter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_operation,
    input  logic [3:0]                          i_new_month,
    input  logic [4:0]                          i_new_day,
    input  logic [11:0]                         i_new_year,
    input  logic [caldc_pkg::COUNT_BITS-1:0]    i_day_count,
    output logic                                o_valid,
    output logic [4:0]                          o_prior_day,
    output logic [3:0]                          o_prior_month,
    output logic [caldc_pkg::YEAR_BITS-1:0]     o_prior_year,
    output logic [4:0]                          o_cur_day,
    output logic [3:0]                          o_cur_month,
    output logic [caldc_pkg::YEAR_BITS-1:0]     o_cur_year
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_STEP = 2'b10
    } t_state;

    t_state                           r_state, n_state;
    caldc_pkg::t_date                 r_date,  n_date;
    caldc_pkg::t_date                 r_prior, n_prior;
    logic [caldc_pkg::COUNT_BITS-1:0] r_count, n_count;
    logic                             r_back,  n_back;
    logic                             r_valid, n_valid;

    caldc_pkg::t_date                 w_step_date;
    caldc_pkg::t_date                 w_set_date;
    logic                             w_accept;
    logic [caldc_pkg::YEAR_BITS-1:0]  w_new_year;
    logic [4:0]                       w_set_len;

    // shared one-day step unit
    caldc_step u_step (
        .i_date (r_date),
        .i_back (r_back),
        .o_date (w_step_date)
    );

    assign w_accept   = start && !busy;
    assign w_new_year = caldc_pkg::YEAR_BITS'(i_new_year);

    // checked date for a set command
    always_comb begin
        if ((i_new_month >= caldc_pkg::MONTH_JAN) && (i_new_month <= caldc_pkg::MONTH_DEC)) begin
            w_set_date.month = i_new_month;
        end else begin
            w_set_date.month = caldc_pkg::MONTH_JAN;
        end
        if ((w_new_year >= caldc_pkg::YEAR_LOW) && (w_new_year <= caldc_pkg::YEAR_HIGH)) begin
            w_set_date.year = w_new_year;
        end else begin
            w_set_date.year = caldc_pkg::YEAR_LOW;
        end
        w_set_len = caldc_pkg::days_in(w_set_date.month, w_set_date.year);
        if ((i_new_day >= 5'd1) && (i_new_day <= w_set_len)) begin
            w_set_date.day = i_new_day;
        end else begin
            w_set_date.day = 5'd1;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_date  = r_date;
        n_prior = r_prior;
        n_count = r_count;
        n_back  = r_back;
        n_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_prior = r_date;
                    n_state = ST_STEP;
                    n_count = '0;
                    case (i_operation)
                        caldc_pkg::OP_SET: begin
                            n_date = w_set_date;
                        end
                        caldc_pkg::OP_FWD: begin
                            n_count = i_day_count;
                            n_back  = 1'b0;
                        end
                        caldc_pkg::OP_BACK: begin
                            n_count = i_day_count;
                            n_back  = 1'b1;
                        end
                        default: begin
                            n_count = '0;
                        end
                    endcase
                end
            end
            ST_STEP: begin
                if (r_count == '0) begin
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_date  = w_step_date;
                    n_count = r_count - caldc_pkg::COUNT_BITS'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_date  <= '{year: caldc_pkg::YEAR_LOW, month: caldc_pkg::MONTH_JAN, day: 5'd1};
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_date  <= n_date;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_prior <= n_prior;
        r_count <= n_count;
        r_back  <= n_back;
    end

    // outputs
    assign busy          = (r_state != ST_IDLE);
    assign o_valid       = r_valid;
    assign o_prior_day   = r_prior.day;
    assign o_prior_month = r_prior.month;
    assign o_prior_year  = r_prior.year;
    assign o_cur_day     = r_date.day;
    assign o_cur_month   = r_date.month;
    assign o_cur_year    = r_date.year;

endmodule
